// ===== hdl/vna_pkg.sv =====
// shared constants, codes and payload types for the vertex normal accumulator
// no dependencies
package vna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int POS_W        = 12;
  localparam int VEC_W        = 27;
  localparam int MAG_W        = VEC_W;
  localparam int SQ_W         = 56;
  localparam int ROOT_W       = SQ_W / 2;
  localparam int SUM_W        = 21;
  localparam int NRM_W        = 16;
  localparam int QUO_W        = 15;
  localparam int ONE_Q14      = 16384;
  localparam int SUM_MAX      = 1048575;
  localparam int SUM_MIN      = -1048576;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TRI   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } norm3_t;

endpackage

// ===== hdl/vna_unit.sv =====
// iterative unit-length scaler: squares, bitwise integer square root, long division
// depends on vna_pkg
module vna_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  vna_pkg::vec3_t     vec,
  output logic               done,
  output vna_pkg::norm3_t    res
);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_SQ   = 4'b0010,
    U_ROOT = 4'b0100,
    U_DIV  = 4'b1000
  } ustate_t;

  ustate_t state;
  logic [4:0] cnt;
  logic [1:0] comp;
  vna_pkg::vec3_t v;
  logic [2*vna_pkg::MAG_W-1:0] sqp;
  logic [vna_pkg::SQ_W-1:0] sq;
  logic [vna_pkg::SQ_W-1:0] n_r;
  logic [vna_pkg::ROOT_W+1:0] rem;
  logic [vna_pkg::ROOT_W-1:0] root;
  logic [vna_pkg::ROOT_W:0] drem;
  logic [vna_pkg::QUO_W-1:0] quo;
  logic signed [vna_pkg::NRM_W-1:0] res_a [3];

  logic signed [vna_pkg::VEC_W-1:0] sel;
  logic [vna_pkg::MAG_W-1:0] mag;
  logic [vna_pkg::ROOT_W+1:0] rem_s, trial;
  logic [vna_pkg::ROOT_W:0] cur;
  logic ge;
  logic [vna_pkg::QUO_W-1:0] quo_next;
  logic signed [vna_pkg::NRM_W-1:0] signed_q;

  always_comb begin
    unique case (comp)
      2'd0:    sel = v.x;
      2'd1:    sel = v.y;
      default: sel = v.z;
    endcase
    mag   = sel[vna_pkg::VEC_W-1] ? vna_pkg::MAG_W'(-sel) : vna_pkg::MAG_W'(sel);
    rem_s = {rem[vna_pkg::ROOT_W-1:0], n_r[vna_pkg::SQ_W-1 -: 2]};
    trial = {root, 2'b01};
    cur   = (cnt == 5'd0) ? {1'b0, 1'b0, mag} : {drem[vna_pkg::ROOT_W-1:0], 1'b0};
    ge    = cur >= {1'b0, root};
    quo_next = {quo[vna_pkg::QUO_W-2:0], ge};
    if (root == '0) begin
      signed_q = '0;
    end else if (sel[vna_pkg::VEC_W-1]) begin
      signed_q = -vna_pkg::NRM_W'({1'b0, quo_next});
    end else begin
      signed_q = vna_pkg::NRM_W'({1'b0, quo_next});
    end
  end

  assign res = '{x: res_a[0], y: res_a[1], z: res_a[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (start) begin
            v     <= vec;
            cnt   <= '0;
            comp  <= 2'd0;
            sq    <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          // multiply one component per cycle, sum behind the product register
          sqp <= mag * mag;
          if (cnt != 5'd0) begin
            sq <= sq + vna_pkg::SQ_W'(sqp);
          end
          comp <= comp + 2'd1;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            n_r   <= sq + vna_pkg::SQ_W'(sqp);
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= U_ROOT;
          end
        end
        U_ROOT: begin
          if (rem_s >= trial) begin
            rem  <= rem_s - trial;
            root <= {root[vna_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_s;
            root <= {root[vna_pkg::ROOT_W-2:0], 1'b0};
          end
          n_r <= n_r << 2;
          cnt <= cnt + 5'd1;
          if (cnt == 5'(vna_pkg::ROOT_W - 1)) begin
            cnt   <= '0;
            comp  <= 2'd0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          drem <= ge ? cur - {1'b0, root} : cur;
          quo  <= quo_next;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'(vna_pkg::QUO_W - 1)) begin
            res_a[comp] <= signed_q;
            cnt <= '0;
            if (comp == 2'd2) begin
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              comp <= comp + 2'd1;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/vertex_normal_accumulator_top.sv =====
// vertex normal accumulator: sequencer, vertex and sum memories, cross product
// depends on vna_pkg and vna_unit
// the unit's 4 square, 28 root and 45 division steps dominate triangles and nonzero reads,
// and output stalls add to every kind of item
// in_stall is high from accept until the result is handed to the output register
// reset (synchronous) empties the mesh and the output register; memories are not cleared
module vertex_normal_accumulator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic signed [11:0] pos_x,
  input  logic signed [11:0] pos_y,
  input  logic signed [11:0] pos_z,
  input  logic [15:0] corner_a,
  input  logic [15:0] corner_b,
  input  logic [15:0] corner_c,
  input  logic [15:0] query_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [1:0]  status
);

  localparam int PW = 3 * vna_pkg::POS_W;
  localparam int SW = 3 * vna_pkg::SUM_W;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_FETCH   = 9'b000000010,
    S_CROSS   = 9'b000000100,
    S_UNIT    = 9'b000001000,
    S_RMW_RD  = 9'b000010000,
    S_RMW_WR  = 9'b000100000,
    S_SUM_RD  = 9'b001000000,
    S_SUM_CHK = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t state;
  logic [vna_pkg::CNT_W-1:0] count;
  logic [1:0] mode_r;
  logic [vna_pkg::IDX_W-1:0] corner_r [3];
  logic [vna_pkg::IDX_W-1:0] q_r;
  logic [PW-1:0] vtx [3];
  logic [2:0] step;
  logic [1:0] cr_idx;
  logic signed [25:0] prod;
  logic signed [vna_pkg::VEC_W-1:0] cr [3];
  vna_pkg::norm3_t nrm;
  vna_pkg::norm3_t res_r;
  logic [1:0] status_r;
  logic unit_start;
  vna_pkg::vec3_t unit_vec;
  logic unit_done;
  vna_pkg::norm3_t unit_res;

  // memories
  logic [PW-1:0] pos_mem [vna_pkg::MAX_VERTICES];
  logic [SW-1:0] sum_mem [vna_pkg::MAX_VERTICES];
  logic [PW-1:0] pos_rdata;
  logic [SW-1:0] sum_rdata;
  logic [vna_pkg::IDX_W-1:0] pos_raddr, sum_raddr, sum_waddr;
  logic pos_we, sum_we;
  logic [SW-1:0] sum_wdata;

  logic accept;
  logic out_free;
  logic range_tri, range_rd, full;
  logic signed [12:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [12:0] ma, mb;

  function automatic logic signed [vna_pkg::SUM_W-1:0] sat_add(
    input logic signed [vna_pkg::SUM_W-1:0] s,
    input logic signed [vna_pkg::NRM_W-1:0] n
  );
    logic signed [vna_pkg::SUM_W:0] t;
    t = (vna_pkg::SUM_W+1)'(s) + (vna_pkg::SUM_W+1)'(n);
    if (t > (vna_pkg::SUM_W+1)'(vna_pkg::SUM_MAX)) begin
      return vna_pkg::SUM_W'(vna_pkg::SUM_MAX);
    end else if (t < (vna_pkg::SUM_W+1)'(vna_pkg::SUM_MIN)) begin
      return vna_pkg::SUM_W'(vna_pkg::SUM_MIN);
    end
    return t[vna_pkg::SUM_W-1:0];
  endfunction

  function automatic logic signed [12:0] pdiff(input logic [PW-1:0] p, input logic [PW-1:0] q,
                                               input int sh);
    logic signed [11:0] a, b;
    a = p[sh +: vna_pkg::POS_W];
    b = q[sh +: vna_pkg::POS_W];
    return 13'(a) - 13'(b);
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign full      = (count == vna_pkg::CNT_W'(vna_pkg::MAX_VERTICES));
  assign range_tri = (32'(corner_a) >= 32'(count)) || (32'(corner_b) >= 32'(count)) ||
                     (32'(corner_c) >= 32'(count));
  assign range_rd  = 32'(query_index) >= 32'(count);

  // edges: e1 = b - a, e2 = c - a; x in the top field
  assign e1x = pdiff(vtx[1], vtx[0], 2 * vna_pkg::POS_W);
  assign e1y = pdiff(vtx[1], vtx[0], vna_pkg::POS_W);
  assign e1z = pdiff(vtx[1], vtx[0], 0);
  assign e2x = pdiff(vtx[2], vtx[0], 2 * vna_pkg::POS_W);
  assign e2y = pdiff(vtx[2], vtx[0], vna_pkg::POS_W);
  assign e2z = pdiff(vtx[2], vtx[0], 0);

  // cross product component that the previous step's product belongs to
  assign cr_idx = 2'((step - 3'd1) >> 1);

  // operand order for the six cross product terms
  always_comb begin
    unique case (step)
      3'd0:    begin ma = e1y; mb = e2z; end
      3'd1:    begin ma = e1z; mb = e2y; end
      3'd2:    begin ma = e1z; mb = e2x; end
      3'd3:    begin ma = e1x; mb = e2z; end
      3'd4:    begin ma = e1x; mb = e2y; end
      default: begin ma = e1y; mb = e2x; end
    endcase
  end

  // memory address and write selection
  always_comb begin
    pos_raddr = corner_r[(step < 3'd3) ? step[1:0] : 2'd0];
    // a read keeps the queried sum on the read port until the unit has taken it
    sum_raddr = (mode_r == vna_pkg::MODE_READ) ? q_r :
                corner_r[(step < 3'd3) ? step[1:0] : 2'd0];
    pos_we    = accept && (mode == vna_pkg::MODE_LOAD) && !full;
    sum_we    = pos_we || (state == S_RMW_WR);
    sum_waddr = pos_we ? count[vna_pkg::IDX_W-1:0] : sum_raddr;
    if (pos_we) begin
      sum_wdata = '0;
    end else begin
      sum_wdata = {sat_add(sum_rdata[2*vna_pkg::SUM_W +: vna_pkg::SUM_W], nrm.x),
                   sat_add(sum_rdata[vna_pkg::SUM_W +: vna_pkg::SUM_W], nrm.y),
                   sat_add(sum_rdata[0 +: vna_pkg::SUM_W], nrm.z)};
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[count[vna_pkg::IDX_W-1:0]] <= {pos_x, pos_y, pos_z};
    end
    pos_rdata <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rdata <= sum_mem[sum_raddr];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      unit_start <= 1'b0;
    end else begin
      unit_start <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode_r      <= mode;
            corner_r[0] <= corner_a[vna_pkg::IDX_W-1:0];
            corner_r[1] <= corner_b[vna_pkg::IDX_W-1:0];
            corner_r[2] <= corner_c[vna_pkg::IDX_W-1:0];
            q_r         <= query_index[vna_pkg::IDX_W-1:0];
            res_r       <= '0;
            status_r    <= vna_pkg::ST_OK;
            step        <= '0;
            state       <= S_DONE;
            unique case (mode)
              vna_pkg::MODE_LOAD: begin
                if (full) begin
                  status_r <= vna_pkg::ST_FULL;
                end else begin
                  count <= count + vna_pkg::CNT_W'(1);
                end
              end
              vna_pkg::MODE_TRI: begin
                if (range_tri) begin
                  status_r <= vna_pkg::ST_RANGE;
                end else begin
                  state <= S_FETCH;
                end
              end
              vna_pkg::MODE_READ: begin
                if (range_rd) begin
                  status_r <= vna_pkg::ST_RANGE;
                end else begin
                  state <= S_SUM_RD;
                end
              end
              default: count <= '0;
            endcase
          end
        end
        S_FETCH: begin
          // address for corner k goes out at step k, data lands one step later
          if (step != 3'd0) begin
            vtx[step[1:0] - 2'd1] <= pos_rdata;
          end
          step <= step + 3'd1;
          if (step == 3'd3) begin
            step  <= '0;
            state <= S_CROSS;
          end
        end
        S_CROSS: begin
          prod <= ma * mb;
          if (step != 3'd0) begin
            if (step[0]) begin
              cr[cr_idx] <= vna_pkg::VEC_W'(prod);
            end else begin
              cr[cr_idx] <= cr[cr_idx] - vna_pkg::VEC_W'(prod);
            end
          end
          step <= step + 3'd1;
          if (step == 3'd6) begin
            unit_start <= 1'b1;
            state      <= S_UNIT;
          end
        end
        S_UNIT: begin
          if (unit_done) begin
            step <= '0;
            if (mode_r == vna_pkg::MODE_TRI) begin
              nrm   <= unit_res;
              state <= S_RMW_RD;
            end else begin
              res_r <= unit_res;
              state <= S_DONE;
            end
          end
        end
        S_RMW_RD: state <= S_RMW_WR;
        S_RMW_WR: begin
          // one corner per pass, the write lands before the next read
          if (step == 3'd2) begin
            state <= S_DONE;
          end else begin
            step  <= step + 3'd1;
            state <= S_RMW_RD;
          end
        end
        S_SUM_RD: state <= S_SUM_CHK;
        S_SUM_CHK: begin
          if (sum_rdata == '0) begin
            res_r <= '{x: '0, y: vna_pkg::NRM_W'(vna_pkg::ONE_Q14), z: '0};
            state <= S_DONE;
          end else begin
            unit_start <= 1'b1;
            state      <= S_UNIT;
          end
        end
        S_DONE: begin
          if (out_free) begin
            normal_x  <= res_r.x;
            normal_y  <= res_r.y;
            normal_z  <= res_r.z;
            status    <= status_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // unit input: cross product for triangles, widened sum for reads
  always_comb begin
    if (mode_r == vna_pkg::MODE_TRI) begin
      unit_vec = '{x: cr[0], y: cr[1], z: cr[2]};
    end else begin
      unit_vec.x = vna_pkg::VEC_W'($signed(sum_rdata[2*vna_pkg::SUM_W +: vna_pkg::SUM_W]));
      unit_vec.y = vna_pkg::VEC_W'($signed(sum_rdata[vna_pkg::SUM_W +: vna_pkg::SUM_W]));
      unit_vec.z = vna_pkg::VEC_W'($signed(sum_rdata[0 +: vna_pkg::SUM_W]));
    end
  end

  vna_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (unit_start),
    .vec   (unit_vec),
    .done  (unit_done),
    .res   (unit_res)
  );

endmodule

// ===== hdl/vna_checker.sv =====
// port-level checks for the vertex normal accumulator, bound to the top level
// depends on vna_pkg and vertex_normal_accumulator_top
module vna_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z,
  input logic [1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not held off after accept");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == vna_pkg::ST_OK || status == vna_pkg::ST_RANGE ||
                   status == vna_pkg::ST_FULL))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != vna_pkg::ST_OK |-> normal_x == 0 && normal_y == 0 && normal_z == 0)
    else $error("nonzero normal on error beat");

endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .normal_x  (normal_x),
  .normal_y  (normal_y),
  .normal_z  (normal_z),
  .status    (status)
);

// ===== sim/vna_scoreboard.sv =====
// checker for the vertex normal accumulator: watches both channels, predicts each result
// from its own copy of the mesh state and compares beats in order
// depends on vna_pkg
module vna_scoreboard (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         mode,
  input  logic signed [11:0] pos_x,
  input  logic signed [11:0] pos_y,
  input  logic signed [11:0] pos_z,
  input  logic [15:0]        corner_a,
  input  logic [15:0]        corner_b,
  input  logic [15:0]        corner_c,
  input  logic [15:0]        query_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct packed {
    logic signed [vna_pkg::NRM_W-1:0] x;
    logic signed [vna_pkg::NRM_W-1:0] y;
    logic signed [vna_pkg::NRM_W-1:0] z;
    logic [1:0]                       st;
  } normal_beat_t;

  logic signed [vna_pkg::POS_W-1:0] mesh_pos [vna_pkg::MAX_VERTICES][3];
  int                               mesh_sum [vna_pkg::MAX_VERTICES][3];
  int                               mesh_count;
  normal_beat_t                     normals_due [$];

  assign outstanding = normals_due.size();

  // floor square root, two bits of the radicand per step
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned acc;
    longint unsigned probe;
    acc   = 0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= acc + probe) begin
        n   = n - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    return acc;
  endfunction

  // scale a vector to unit length in Q1.14, truncating, clamped to +-1.0
  function automatic normal_beat_t to_unit(longint vx, longint vy, longint vz);
    longint          comp [3];
    longint unsigned mag;
    longint unsigned len;
    longint          q;
    normal_beat_t    r;
    comp = '{vx, vy, vz};
    mag  = 0;
    for (int i = 0; i < 3; i++) begin
      q   = comp[i] < 0 ? -comp[i] : comp[i];
      mag = mag + longint'(q) * longint'(q);
    end
    len = floor_root(mag);
    for (int i = 0; i < 3; i++) begin
      q = (len == 0) ? 0 : (comp[i] * vna_pkg::ONE_Q14) / longint'(len);
      if (q > vna_pkg::ONE_Q14) q = vna_pkg::ONE_Q14;
      if (q < -vna_pkg::ONE_Q14) q = -vna_pkg::ONE_Q14;
      comp[i] = q;
    end
    r.x  = vna_pkg::NRM_W'(comp[0]);
    r.y  = vna_pkg::NRM_W'(comp[1]);
    r.z  = vna_pkg::NRM_W'(comp[2]);
    r.st = vna_pkg::ST_OK;
    return r;
  endfunction

  function automatic void add_clamped(int idx, normal_beat_t n);
    longint s;
    longint add [3];
    add = '{longint'(n.x), longint'(n.y), longint'(n.z)};
    for (int i = 0; i < 3; i++) begin
      s = longint'(mesh_sum[idx][i]) + add[i];
      if (s > vna_pkg::SUM_MAX) s = vna_pkg::SUM_MAX;
      if (s < vna_pkg::SUM_MIN) s = vna_pkg::SUM_MIN;
      mesh_sum[idx][i] = int'(s);
    end
  endfunction

  function automatic normal_beat_t predict_normal();
    normal_beat_t r;
    normal_beat_t face;
    longint       e1 [3];
    longint       e2 [3];
    int           a, b, c, q;
    r = '0;
    r.st = vna_pkg::ST_OK;
    case (mode)
      vna_pkg::MODE_LOAD: begin
        if (mesh_count >= vna_pkg::MAX_VERTICES) begin
          r.st = vna_pkg::ST_FULL;
        end else begin
          mesh_pos[mesh_count][0] = pos_x;
          mesh_pos[mesh_count][1] = pos_y;
          mesh_pos[mesh_count][2] = pos_z;
          for (int i = 0; i < 3; i++) mesh_sum[mesh_count][i] = 0;
          mesh_count++;
        end
      end
      vna_pkg::MODE_TRI: begin
        a = int'(corner_a);
        b = int'(corner_b);
        c = int'(corner_c);
        if (a >= mesh_count || b >= mesh_count || c >= mesh_count) begin
          r.st = vna_pkg::ST_RANGE;
        end else begin
          for (int i = 0; i < 3; i++) begin
            e1[i] = longint'(mesh_pos[b][i]) - longint'(mesh_pos[a][i]);
            e2[i] = longint'(mesh_pos[c][i]) - longint'(mesh_pos[a][i]);
          end
          face = to_unit(e1[1] * e2[2] - e1[2] * e2[1],
                         e1[2] * e2[0] - e1[0] * e2[2],
                         e1[0] * e2[1] - e1[1] * e2[0]);
          add_clamped(a, face);
          add_clamped(b, face);
          add_clamped(c, face);
        end
      end
      vna_pkg::MODE_READ: begin
        q = int'(query_index);
        if (q >= mesh_count) begin
          r.st = vna_pkg::ST_RANGE;
        end else if (mesh_sum[q][0] == 0 && mesh_sum[q][1] == 0 && mesh_sum[q][2] == 0) begin
          r.y = vna_pkg::NRM_W'(vna_pkg::ONE_Q14);
        end else begin
          r = to_unit(mesh_sum[q][0], mesh_sum[q][1], mesh_sum[q][2]);
        end
      end
      default: begin
        mesh_count = 0;
        for (int v = 0; v < vna_pkg::MAX_VERTICES; v++)
          for (int i = 0; i < 3; i++) mesh_sum[v][i] = 0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    normal_beat_t got;
    normal_beat_t want;
    if (rst) begin
      fail_count = 0;
      mesh_count = 0;
      normals_due.delete();
    end else begin
      if (in_valid && !in_stall) normals_due = {normals_due, predict_normal()};
      if (out_valid && !out_stall) begin
        got = '{normal_x, normal_y, normal_z, status};
        if (normals_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: n=(%0d,%0d,%0d) st=%0d",
                     normal_x, normal_y, normal_z, status);
        end else begin
          want = normals_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: want n=(%0d,%0d,%0d) st=%0d got n=(%0d,%0d,%0d) st=%0d",
                       want.x, want.y, want.z, want.st,
                       normal_x, normal_y, normal_z, status);
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb_vertex_normal_accumulator_top.sv =====
// testbench top for the vertex normal accumulator: drives directed and random meshes,
// applies random idling on both sides and reports the verdict
// depends on vna_pkg, vertex_normal_accumulator_top and vna_scoreboard
module tb_vertex_normal_accumulator_top;

  localparam int IDLE_LIMIT = 3000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = vna_pkg::MODE_CLEAR;
  logic signed [11:0] pos_x = '0;
  logic signed [11:0] pos_y = '0;
  logic signed [11:0] pos_z = '0;
  logic [15:0]        corner_a = '0;
  logic [15:0]        corner_b = '0;
  logic [15:0]        corner_c = '0;
  logic [15:0]        query_index = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic [1:0]         status;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  int beats_sent = 0;
  int meshes_built = 0;
  bit steady = 1'b0;  // when set, neither side inserts gaps

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  vertex_normal_accumulator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .query_index(query_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z), .status(status)
  );

  vna_scoreboard u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .query_index(query_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z), .status(status),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // watchdog: a stretch with no beat on either channel means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each beat, none in steady stretches
  initial begin
    int hold;
    @(negedge rst);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // one input beat: optional gap, then hold the payload until accepted
  task automatic send_beat(logic [1:0] m, logic [11:0] x, logic [11:0] y, logic [11:0] z,
                           logic [15:0] a, logic [15:0] b, logic [15:0] c,
                           logic [15:0] q);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= m;
    pos_x       <= x;
    pos_y       <= y;
    pos_z       <= z;
    corner_a    <= a;
    corner_b    <= b;
    corner_c    <= c;
    query_index <= q;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // unused fields carry random junk so the block must ignore them
  task automatic load_vertex(logic [11:0] x, logic [11:0] y, logic [11:0] z);
    send_beat(vna_pkg::MODE_LOAD, x, y, z, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic add_face(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    send_beat(vna_pkg::MODE_TRI, 12'($urandom), 12'($urandom), 12'($urandom), a, b, c,
              16'($urandom));
  endtask

  task automatic read_normal(logic [15:0] q);
    send_beat(vna_pkg::MODE_READ, 12'($urandom), 12'($urandom), 12'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), q);
  endtask

  task automatic clear_mesh();
    send_beat(vna_pkg::MODE_CLEAR, 12'($urandom), 12'($urandom), 12'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    meshes_built++;
  endtask

  // positions: mostly random, some at the rails, some tiny so faces go flat
  function automatic logic [11:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 12'h800;
      1: return 12'h7ff;
      2: return 12'($urandom_range(0, 2));
      default: return 12'($urandom);
    endcase
  endfunction

  initial begin
    int verts;
    int ops;
    int pick;
    int rand_beats;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty mesh, rail positions, flat and repeated-corner faces
    clear_mesh();
    read_normal(16'd0);                        // nothing loaded yet
    add_face(16'd0, 16'd0, 16'd0);             // out of range on empty mesh
    load_vertex(12'h800, 12'h800, 12'h800);
    load_vertex(12'h7ff, 12'h800, 12'h800);
    load_vertex(12'h800, 12'h7ff, 12'h800);
    load_vertex(12'h800, 12'h800, 12'h7ff);
    load_vertex(12'h7ff, 12'h7ff, 12'h7ff);
    add_face(16'd0, 16'd1, 16'd2);
    add_face(16'd0, 16'd3, 16'd1);
    add_face(16'd2, 16'd2, 16'd1);             // repeated corner adds nothing
    add_face(16'd0, 16'd4, 16'd0);
    add_face(16'd0, 16'd1, 16'hffff);          // index far out of range
    add_face(16'd5, 16'd1, 16'd2);             // index just past the count
    read_normal(16'd0);
    read_normal(16'd1);
    read_normal(16'd4);                        // only in a flat face, so reads as +y
    read_normal(16'd5);
    read_normal(16'hffff);
    // same face many times to drive the sums into saturation
    steady = 1'b1;
    repeat (70) add_face(16'd0, 16'd1, 16'd2);
    steady = 1'b0;
    read_normal(16'd0);
    read_normal(16'd2);
    add_face(16'd2, 16'd1, 16'd0);
    read_normal(16'd1);

    // fill the store, then one more load must be refused
    clear_mesh();
    steady = 1'b1;
    for (int v = 0; v < vna_pkg::MAX_VERTICES; v++)
      load_vertex(pick_coord(), pick_coord(), pick_coord());
    steady = 1'b0;
    load_vertex(12'h123, 12'h456, 12'h789);
    add_face(16'd1021, 16'd1022, 16'd1023);
    add_face(16'd1023, 16'd0, 16'd1024);
    read_normal(16'd1023);
    read_normal(16'd1024);

    // random meshes: mostly in-range faces and reads, some strays
    rand_beats = 0;
    while (rand_beats < 100) begin
      steady = ($urandom_range(0, 3) == 0);
      clear_mesh();
      verts = $urandom_range(3, 24);
      for (int v = 0; v < verts; v++) load_vertex(pick_coord(), pick_coord(), pick_coord());
      ops = $urandom_range(10, 40);
      rand_beats += verts + 1 + ops;
      for (int k = 0; k < ops; k++) begin
        pick = $urandom_range(0, 15);
        if (pick < 9) begin
          add_face(16'($urandom_range(0, verts - 1)), 16'($urandom_range(0, verts - 1)),
                   16'($urandom_range(0, verts - 1)));
        end else if (pick < 13) begin
          read_normal(16'($urandom_range(0, verts - 1)));
        end else if (pick == 13) begin
          add_face(16'($urandom_range(0, verts - 1)), 16'($urandom),
                   16'($urandom_range(0, verts)));
        end else if (pick == 14) begin
          read_normal($urandom_range(0, 1) ? 16'($urandom) : 16'(verts));
        end else begin
          load_vertex(pick_coord(), pick_coord(), pick_coord());
          verts++;
        end
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain, then let the pipeline settle before the verdict
    while (outstanding != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("run covered %0d input beats over %0d meshes, including a full store,",
             beats_sent, meshes_built);
    $display("saturated sums, flat faces and out-of-range indices");
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
